FILE: rtl/double_buffer_transfer_sequencer_top_assert.svh
// Assertion macros for the double buffer transfer sequencer checker.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef DOUBLE_BUFFER_TRANSFER_SEQUENCER_TOP_ASSERT_SVH
`define DOUBLE_BUFFER_TRANSFER_SEQUENCER_TOP_ASSERT_SVH

// check a property outside reset
`define DBTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check a property at every edge, reset included
`define DBTS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: rtl/dbts_pkg.sv
// Package for the double buffer transfer sequencer: command and request codes,
// field widths and the beat structures shared by the modules. No dependencies.
package dbts_pkg;

    localparam int FLEN_W = 24;
    localparam int POS_W  = 24;
    localparam int LEN_W  = 17;
    localparam int CMD_W  = 2;
    localparam int KIND_W = 2;

    localparam logic [CMD_W-1:0] CMD_START      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ_DONE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE_DONE = 2'd2;

    localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [FLEN_W-1:0] file_length;
    } in_beat_t;

    typedef struct packed {
        logic [KIND_W-1:0] request_kind;
        logic              buffer_sel;
        logic [POS_W-1:0]  position;
        logic [LEN_W-1:0]  length;
        logic              last;
    } res_beat_t;

    typedef struct packed {
        logic [1:0] count;
        res_beat_t  res0;
        res_beat_t  res1;
    } push_t;

endpackage

FILE: rtl/dbts_in_reg.sv
// Input register stage of the transfer sequencer: holds one command beat
// until the core takes it. Depends on dbts_pkg.
module dbts_in_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dbts_pkg::in_beat_t s_beat,
    output logic              beat_valid,
    output dbts_pkg::in_beat_t beat,
    input  logic              take
);
    import dbts_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_beat_t beat_reg;

    assign s_ready    = !valid_reg || take;
    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            beat_reg <= s_beat;
        end
    end

endmodule

FILE: rtl/dbts_core.sv
// Sequencer core: transfer state and the single-pass step that turns one
// command beat into up to two request beats. Depends on dbts_pkg.
module dbts_core #(
    parameter int CHUNK_BYTES = 65536,
    parameter int LENGTH_BITS = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               beat_valid,
    input  dbts_pkg::in_beat_t beat,
    input  logic               space_ok,
    output logic               take,
    output dbts_pkg::push_t    push
);
    import dbts_pkg::*;

    localparam int STATE_W = (LENGTH_BITS < FLEN_W) ? LENGTH_BITS : FLEN_W;
    localparam int CALC_W  = FLEN_W + 1;
    localparam logic [CALC_W-1:0] LEN_MAX = CALC_W'((64'd1 << LENGTH_BITS) - 64'd1);
    localparam logic [CALC_W-1:0] CHUNK_C = CALC_W'(CHUNK_BYTES);

    logic               busy_reg,      busy_next;
    logic [STATE_W-1:0] rd_rem_reg,    rd_rem_next;
    logic [STATE_W-1:0] rd_pos_reg,    rd_pos_next;
    logic [STATE_W-1:0] wr_rem_reg,    wr_rem_next;
    logic [STATE_W-1:0] wr_pos_reg,    wr_pos_next;
    logic               cur_buf_reg,   cur_buf_next;
    logic               wr_fin_reg,    wr_fin_next;
    logic               rd_fin_reg,    rd_fin_next;

    logic [CALC_W-1:0]  flen_w;
    logic [STATE_W-1:0] flen_s;
    logic [LEN_W-1:0]   wlen;
    logic [LEN_W-1:0]   rlen;

    function automatic logic [LEN_W-1:0] chunk_of(input logic [STATE_W-1:0] n);
        logic [CALC_W-1:0] nw;
        nw = CALC_W'(n);
        return (nw < CHUNK_C) ? LEN_W'(nw) : LEN_W'(CHUNK_C);
    endfunction

    function automatic logic [STATE_W-1:0] sub_len(input logic [STATE_W-1:0] a,
                                                   input logic [LEN_W-1:0] b);
        return STATE_W'(CALC_W'(a) - CALC_W'(b));
    endfunction

    function automatic logic [STATE_W-1:0] add_len(input logic [STATE_W-1:0] a,
                                                   input logic [LEN_W-1:0] b);
        return STATE_W'(CALC_W'(a) + CALC_W'(b));
    endfunction

    assign take = beat_valid && space_ok;

    always_comb begin
        busy_next    = busy_reg;
        rd_rem_next  = rd_rem_reg;
        rd_pos_next  = rd_pos_reg;
        wr_rem_next  = wr_rem_reg;
        wr_pos_next  = wr_pos_reg;
        cur_buf_next = cur_buf_reg;
        wr_fin_next  = wr_fin_reg;
        rd_fin_next  = rd_fin_reg;
        push         = '0;
        flen_w       = CALC_W'(beat.file_length);
        if (flen_w > LEN_MAX) begin
            flen_w = LEN_MAX;
        end
        flen_s = STATE_W'(flen_w);
        wlen   = chunk_of(wr_rem_reg);
        rlen   = chunk_of(rd_rem_reg);

        if (take) begin
            case (beat.command)
                CMD_START: begin
                    if (!busy_reg) begin
                        busy_next    = 1'b1;
                        cur_buf_next = 1'b0;
                        wr_fin_next  = 1'b1;
                        rd_fin_next  = 1'b0;
                        wr_rem_next  = flen_s;
                        wr_pos_next  = '0;
                        rd_rem_next  = sub_len(flen_s, chunk_of(flen_s));
                        rd_pos_next  = STATE_W'(chunk_of(flen_s));
                        push.count   = 2'd1;
                        push.res0    = '{KIND_READ, 1'b0, '0, chunk_of(flen_s), 1'b1};
                    end
                end
                CMD_READ_DONE, CMD_WRITE_DONE: begin
                    if (busy_reg) begin
                        rd_fin_next = rd_fin_reg || (beat.command == CMD_READ_DONE);
                        wr_fin_next = wr_fin_reg || (beat.command == CMD_WRITE_DONE);
                        if (rd_fin_next && wr_fin_next) begin
                            if (wr_rem_reg == '0) begin
                                busy_next  = 1'b0;
                                push.count = 2'd1;
                                push.res0  = '{KIND_DONE, 1'b0, '0, '0, 1'b1};
                            end else begin
                                wr_rem_next  = sub_len(wr_rem_reg, wlen);
                                wr_pos_next  = add_len(wr_pos_reg, wlen);
                                wr_fin_next  = 1'b0;
                                cur_buf_next = !cur_buf_reg;
                                push.res0    = '{KIND_WRITE, cur_buf_reg,
                                                 POS_W'(wr_pos_reg), wlen, 1'b0};
                                if (rd_rem_reg != '0) begin
                                    rd_rem_next = sub_len(rd_rem_reg, rlen);
                                    rd_pos_next = add_len(rd_pos_reg, rlen);
                                    rd_fin_next = 1'b0;
                                    push.count  = 2'd2;
                                    push.res1   = '{KIND_READ, !cur_buf_reg,
                                                    POS_W'(rd_pos_reg), rlen, 1'b1};
                                end else begin
                                    push.count     = 2'd1;
                                    push.res0.last = 1'b1;
                                end
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            rd_rem_reg  <= '0;
            rd_pos_reg  <= '0;
            wr_rem_reg  <= '0;
            wr_pos_reg  <= '0;
            cur_buf_reg <= 1'b0;
            wr_fin_reg  <= 1'b0;
            rd_fin_reg  <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            rd_rem_reg  <= rd_rem_next;
            rd_pos_reg  <= rd_pos_next;
            wr_rem_reg  <= wr_rem_next;
            wr_pos_reg  <= wr_pos_next;
            cur_buf_reg <= cur_buf_next;
            wr_fin_reg  <= wr_fin_next;
            rd_fin_reg  <= rd_fin_next;
        end
    end

endmodule

FILE: rtl/dbts_out_fifo.sv
// Four-entry result queue of the transfer sequencer: takes up to two request
// beats per cycle and presents one per cycle while m_ready is high. Depends on dbts_pkg.
module dbts_out_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  dbts_pkg::push_t     push,
    output logic                space_ok,
    output logic                m_valid,
    input  logic                m_ready,
    output dbts_pkg::res_beat_t m_beat
);
    import dbts_pkg::*;

    res_beat_t  entries_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg,  count_next;
    logic       pop;

    assign m_valid  = count_reg != 3'd0;
    assign m_beat   = entries_reg[rd_ptr_reg];
    assign space_ok = count_reg <= 3'd2;
    assign pop      = m_valid && m_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + push.count;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push.count} - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entries_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.count == 2'd2) begin
            entries_reg[wr_ptr_reg + 2'd1] <= push.res1;
        end
    end

endmodule

FILE: rtl/double_buffer_transfer_sequencer_top.sv
// Double buffer transfer sequencer, top level.
// Depends on dbts_pkg, dbts_in_reg, dbts_core and dbts_out_fifo.
//
// Usage:
//   The s_ channel carries command beats: start load (with file_length),
//   disk read finished, memory write finished. The m_ channel carries request
//   beats: disk read, memory write or load complete, with buffer, position and
//   length; m_last marks the final request caused by one command.
//   A start issues a read into buffer 0. Once both the disk and memory flags
//   are set, a write from the current buffer follows, then a read into the
//   other buffer while file data remains. Starts while busy, events while
//   idle and unknown commands give no requests.
//   The first request of a command passes through the input register and then
//   the result queue before it is valid. A command is taken every cycle while
//   the result queue has room for two requests; it drains one request per cycle
//   while m_ready is high, so commands that cause two requests go at its pace.
//   Reset clears the transfer state and empties the queue. When the receiver
//   stalls, the core holds once three requests wait in the queue, and s_ready
//   drops with one more command held in the input register, after at most
//   four commands that cause requests.
module double_buffer_transfer_sequencer_top #(
    parameter int CHUNK_BYTES = 65536,
    parameter int LENGTH_BITS = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [dbts_pkg::CMD_W-1:0]          s_command,
    input  logic [dbts_pkg::FLEN_W-1:0]         s_file_length,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [dbts_pkg::KIND_W-1:0]         m_request_kind,
    output logic                                m_buffer_sel,
    output logic [dbts_pkg::POS_W-1:0]          m_position,
    output logic [dbts_pkg::LEN_W-1:0]          m_length,
    output logic                                m_last
);
    import dbts_pkg::*;

    in_beat_t  s_beat;
    in_beat_t  beat;
    logic      beat_valid;
    logic      take;
    logic      space_ok;
    push_t     push;
    res_beat_t m_beat;

    assign s_beat.command     = s_command;
    assign s_beat.file_length = s_file_length;

    dbts_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_beat     (s_beat),
        .beat_valid (beat_valid),
        .beat       (beat),
        .take       (take)
    );

    dbts_core #(
        .CHUNK_BYTES (CHUNK_BYTES),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beat_valid (beat_valid),
        .beat       (beat),
        .space_ok   (space_ok),
        .take       (take),
        .push       (push)
    );

    dbts_out_fifo u_out_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .space_ok (space_ok),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_beat   (m_beat)
    );

    assign m_request_kind = m_beat.request_kind;
    assign m_buffer_sel   = m_beat.buffer_sel;
    assign m_position     = m_beat.position;
    assign m_length       = m_beat.length;
    assign m_last         = m_beat.last;

endmodule

FILE: rtl/dbts_checker.sv
// Port checker for the double buffer transfer sequencer and its bind.
// Depends on dbts_pkg and double_buffer_transfer_sequencer_top_assert.svh.
`include "double_buffer_transfer_sequencer_top_assert.svh"

module dbts_checker #(
    parameter int CHUNK_BYTES = 65536
) (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [dbts_pkg::KIND_W-1:0] m_request_kind,
    input logic                        m_buffer_sel,
    input logic [dbts_pkg::POS_W-1:0]  m_position,
    input logic [dbts_pkg::LEN_W-1:0]  m_length,
    input logic                        m_last
);
    import dbts_pkg::*;

    localparam logic [LEN_W-1:0] CHUNK_L = LEN_W'(CHUNK_BYTES);

    `DBTS_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid, "request beat right after reset")
    `DBTS_ASSERT(a_hold, m_valid && !m_ready |=> m_valid && $stable(m_position) && $stable(m_length), "stalled request beat changed")
    `DBTS_ASSERT(a_done_clean, m_valid && m_request_kind == KIND_DONE |-> m_last && !m_buffer_sel && m_position == '0 && m_length == '0, "load complete beat malformed")
    `DBTS_ASSERT(a_chunk_bound, m_valid |-> m_length <= CHUNK_L, "request longer than one chunk")
    `DBTS_ASSERT(a_write_then_last, m_valid && m_ready && m_request_kind == KIND_WRITE && !m_last |=> m_valid && m_request_kind == KIND_READ && m_last, "write without its follow-up read")

endmodule

bind double_buffer_transfer_sequencer_top dbts_checker #(
    .CHUNK_BYTES (CHUNK_BYTES)
) u_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_request_kind (m_request_kind),
    .m_buffer_sel   (m_buffer_sel),
    .m_position     (m_position),
    .m_length       (m_length),
    .m_last         (m_last)
);

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Testbench for double_buffer_transfer_sequencer_top: drives file copy commands
// and checks every request beat against an in-bench model of the sequencer.
// Depends on dbts_pkg and the RTL of the block.
module testbench;
    import dbts_pkg::*;

    localparam int CHUNK = 65536;
    localparam int HOLD_CYCLES = 120;
    localparam int RANDOM_ITEMS = 300;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [CMD_W-1:0]  s_command;
    logic [FLEN_W-1:0] s_file_length;
    logic              m_valid;
    logic              m_ready;
    logic [KIND_W-1:0] m_request_kind;
    logic              m_buffer_sel;
    logic [POS_W-1:0]  m_position;
    logic [LEN_W-1:0]  m_length;
    logic              m_last;

    // transfer state of the sequencer as the bench tracks it
    bit                copy_busy = 1'b0;
    logic [FLEN_W-1:0] rd_left = '0;
    logic [POS_W-1:0]  rd_pos = '0;
    logic [FLEN_W-1:0] wr_left = '0;
    logic [POS_W-1:0]  wr_pos = '0;
    logic              cur_buf = 1'b0;
    bit                wr_flag = 1'b0;
    bit                rd_flag = 1'b0;

    res_beat_t req_expect_q[$];
    int        mismatch_cnt = 0;
    int        work_cnt = 0;
    int        hold_req = 0;
    bit        tx_idle = 1'b1;
    bit        rx_idle = 1'b1;

    double_buffer_transfer_sequencer_top u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_file_length  (s_file_length),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_request_kind (m_request_kind),
        .m_buffer_sel   (m_buffer_sel),
        .m_position     (m_position),
        .m_length       (m_length),
        .m_last         (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(5_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [LEN_W-1:0] chunk_len(logic [FLEN_W-1:0] n);
        return (n < CHUNK) ? n[LEN_W-1:0] : LEN_W'(CHUNK);
    endfunction

    function automatic res_beat_t req_beat(logic [KIND_W-1:0] kind, logic sel,
                                           logic [POS_W-1:0] pos, logic [LEN_W-1:0] len);
        res_beat_t b;
        b.request_kind = kind;
        b.buffer_sel   = sel;
        b.position     = pos;
        b.length       = len;
        b.last         = 1'b0;
        return b;
    endfunction

    function automatic void predict_requests(logic [CMD_W-1:0] cmd, logic [FLEN_W-1:0] flen);
        res_beat_t        batch[$];
        res_beat_t        b;
        logic [LEN_W-1:0] len;
        if (cmd == CMD_START) begin
            if (!copy_busy) begin
                len = chunk_len(flen);
                copy_busy = 1'b1;
                cur_buf = 1'b0;
                wr_flag = 1'b1;
                rd_flag = 1'b0;
                wr_left = flen;
                wr_pos = '0;
                rd_left = flen - FLEN_W'(len);
                rd_pos = POS_W'(len);
                batch = {batch, req_beat(KIND_READ, 1'b0, '0, len)};
            end
        end else if ((cmd == CMD_READ_DONE || cmd == CMD_WRITE_DONE) && copy_busy) begin
            if (cmd == CMD_READ_DONE) begin
                rd_flag = 1'b1;
            end else begin
                wr_flag = 1'b1;
            end
            if (rd_flag && wr_flag) begin
                if (wr_left == 0) begin
                    batch = {batch, req_beat(KIND_DONE, 1'b0, '0, '0)};
                    copy_busy = 1'b0;
                end else begin
                    len = chunk_len(wr_left);
                    batch = {batch, req_beat(KIND_WRITE, cur_buf, wr_pos, len)};
                    wr_left = wr_left - FLEN_W'(len);
                    wr_pos = wr_pos + POS_W'(len);
                    wr_flag = 1'b0;
                    cur_buf = ~cur_buf;
                    if (rd_left != 0) begin
                        len = chunk_len(rd_left);
                        batch = {batch, req_beat(KIND_READ, cur_buf, rd_pos, len)};
                        rd_pos = rd_pos + POS_W'(len);
                        rd_left = rd_left - FLEN_W'(len);
                        rd_flag = 1'b0;
                    end
                end
            end
        end
        foreach (batch[i]) begin
            b = batch[i];
            b.last = (i == batch.size() - 1);
            req_expect_q = {req_expect_q, b};
        end
    endfunction

    task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [FLEN_W-1:0] flen);
        int gap;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_file_length <= flen;
        do @(posedge aclk); while (!s_ready);
        predict_requests(cmd, flen);
    endtask

    task automatic settle_block();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (req_expect_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic send_stray();
        case ($urandom_range(0, 2))
            0: send_cmd(copy_busy ? CMD_START : CMD_UNUSED, FLEN_W'($urandom));
            1: send_cmd(CMD_UNUSED, FLEN_W'($urandom));
            default: begin
                if (wr_flag) begin
                    send_cmd(CMD_WRITE_DONE, FLEN_W'($urandom));
                end else if (rd_flag) begin
                    send_cmd(CMD_READ_DONE, FLEN_W'($urandom));
                end else begin
                    send_cmd(CMD_UNUSED, FLEN_W'($urandom));
                end
            end
        endcase
    endtask

    task automatic finish_file(int noise_pct);
        while (copy_busy) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                send_stray();
            end else begin
                if (!rd_flag && (wr_flag || $urandom_range(0, 1) == 1)) begin
                    send_cmd(CMD_READ_DONE, FLEN_W'($urandom));
                end else begin
                    send_cmd(CMD_WRITE_DONE, FLEN_W'($urandom));
                end
                work_cnt++;
            end
        end
    endtask

    task automatic run_file(logic [FLEN_W-1:0] flen, int noise_pct);
        send_cmd(CMD_START, flen);
        work_cnt++;
        finish_file(noise_pct);
    endtask

    function automatic logic [FLEN_W-1:0] pick_length();
        case ($urandom_range(0, 9))
            0: return '0;
            1, 2: return FLEN_W'($urandom_range(1, 4) * CHUNK + $urandom_range(0, 2) - 1);
            default: return FLEN_W'($urandom_range(1, 5 * CHUNK));
        endcase
    endfunction

    task automatic test_idle_commands();
        send_cmd(CMD_READ_DONE, '1);
        send_cmd(CMD_WRITE_DONE, '0);
        send_cmd(CMD_UNUSED, '1);
        settle_block();
    endtask

    task automatic test_short_files();
        int lens[5];
        lens = '{0, 1, CHUNK - 1, CHUNK, CHUNK + 1};
        foreach (lens[i]) run_file(FLEN_W'(lens[i]), 0);
        settle_block();
    endtask

    task automatic test_ignored_while_busy();
        send_cmd(CMD_START, FLEN_W'(2 * CHUNK));
        send_cmd(CMD_START, '1);
        send_cmd(CMD_WRITE_DONE, '0);
        send_cmd(CMD_UNUSED, '1);
        send_cmd(CMD_READ_DONE, '0);
        send_cmd(CMD_READ_DONE, '1);
        finish_file(0);
        settle_block();
    endtask

    task automatic test_longest_file();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        run_file(FLEN_W'(24 * CHUNK - 1), 0);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        settle_block();
    endtask

    task automatic test_output_stall();
        tx_idle = 1'b0;
        hold_req = HOLD_CYCLES;
        run_file(FLEN_W'(12 * CHUNK), 0);
        tx_idle = 1'b1;
        settle_block();
    endtask

    task automatic test_random_transfers();
        int goal;
        goal = work_cnt + RANDOM_ITEMS;
        while (work_cnt < goal) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0) send_stray();
            run_file(pick_length(), 15);
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        settle_block();
    endtask

    // receiver: random gap after each beat while rx_idle is set, plus a long hold on request
    initial begin
        int wait_left;
        int hold_left;
        wait_left = 0;
        hold_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (m_valid && m_ready) wait_left = rx_idle ? $urandom_range(0, 7) : 0;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (wait_left > 0) begin
                wait_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        res_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (req_expect_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) begin
                    $display("unexpected request: kind %0d buf %0d pos %h len %h last %0d",
                             m_request_kind, m_buffer_sel, m_position, m_length, m_last);
                end
            end else begin
                want = req_expect_q.pop_front();
                if (want.request_kind !== m_request_kind || want.buffer_sel !== m_buffer_sel
                        || want.position !== m_position || want.length !== m_length
                        || want.last !== m_last) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("request mismatch: exp kind %0d buf %0d pos %h len %h last %0d",
                                 want.request_kind, want.buffer_sel, want.position,
                                 want.length, want.last);
                        $display("                  got kind %0d buf %0d pos %h len %h last %0d",
                                 m_request_kind, m_buffer_sel, m_position, m_length, m_last);
                    end
                end
            end
        end
    end

    initial begin
        s_valid <= 1'b0;
        s_command <= CMD_START;
        s_file_length <= '0;
        aresetn <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_idle_commands();
        test_short_files();
        test_ignored_while_busy();
        test_longest_file();
        test_output_stall();
        test_random_transfers();
        if (mismatch_cnt == 0 && req_expect_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
